// File: hw/rtl/dttm_pkg.sv
// Package for the decimal text threshold mask: constants, character codes and parse phase type.
`timescale 1ns / 1ps
package dttm_pkg;

  localparam int VALUES_PER_GROUP_DEF = 4;
  localparam int TOKEN_CAPACITY_DEF   = 31;
  localparam int MASK_BITS            = 4;
  localparam int BYTE_BITS            = 8;

  localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_BITS-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_BITS-1:0] CH_POINT = 8'h2E;
  localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;

  localparam logic [3:0] DIGIT_SEVEN = 4'd7;

  typedef enum logic [5:0] {
    PH_LEAD       = 6'b000001,
    PH_SIGN       = 6'b000010,
    PH_INT        = 6'b000100,
    PH_FRAC_FIRST = 6'b001000,
    PH_FRAC_REST  = 6'b010000,
    PH_END        = 6'b100000
  } phase_t;

endpackage

// File: hw/rtl/decimal_text_threshold_mask.sv
// Top level: parses text tokens as decimals; per group, masks values above 0.7 in magnitude.
// out_tvalid rises the cycle after the delimiter that completes a group; the mask is registered.
// Throughput: one byte per cycle; in_tready drops only while a mask waits and out_tready is low.
// Each byte updates the parse state registers directly; the mask sits in one output register.
// Reset: synchronous, active low; clears token state, value count, mask_acc_r and out_tvalid.
// No clearing pass after reset; bytes are taken in the first cycle after rst_n rises.
`timescale 1ns / 1ps
module decimal_text_threshold_mask
  import dttm_pkg::*;
#(
  parameter int VALUES_PER_GROUP = VALUES_PER_GROUP_DEF,
  parameter int TOKEN_CAPACITY   = TOKEN_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] led_mask, [7:4] zero
);

  localparam int TLW = $clog2(TOKEN_CAPACITY + 1);
  localparam int VCW = $clog2(VALUES_PER_GROUP) + 1;

  logic [TLW-1:0]       token_length_r, token_length_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 int_nz_r, int_nz_nxt;
  logic [3:0]           frac_first_r, frac_first_nxt;
  logic                 frac_tail_r, frac_tail_nxt;
  logic [VCW-1:0]       value_count_r, value_count_nxt;
  logic [MASK_BITS-1:0] mask_acc_r, mask_acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MASK_BITS-1:0] out_mask_r, out_mask_nxt;

  logic                 in_xfer;
  logic                 is_delim;
  logic                 is_dig;
  logic [3:0]           dig;
  logic                 lead_ws;
  logic                 above;
  logic                 emit;
  logic [BYTE_BITS-1:0] c;

  assign c         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_delim  = (c == CH_SPACE) || (c == CH_LF);
  assign is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig       = is_dig ? 4'(c - CH_ZERO) : 4'd0;
  assign lead_ws   = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  assign above     = int_nz_r || (frac_first_r > DIGIT_SEVEN) ||
                     ((frac_first_r == DIGIT_SEVEN) && frac_tail_r);

  always_comb begin
    token_length_nxt = token_length_r;
    phase_nxt        = phase_r;
    int_nz_nxt       = int_nz_r;
    frac_first_nxt   = frac_first_r;
    frac_tail_nxt    = frac_tail_r;
    value_count_nxt  = value_count_r;
    mask_acc_nxt     = mask_acc_r;
    emit             = 1'b0;

    if (in_xfer) begin
      if (!is_delim) begin
        if (int'(token_length_r) < TOKEN_CAPACITY) begin
          token_length_nxt = token_length_r + 1'b1;
          case (phase_r)
            PH_LEAD, PH_SIGN, PH_INT: begin
              if ((phase_r == PH_LEAD) && lead_ws) begin
                phase_nxt = PH_LEAD;
              end else if ((phase_r == PH_LEAD) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                phase_nxt = PH_SIGN;
              end else if (is_dig) begin
                if (dig != 4'd0) int_nz_nxt = 1'b1;
                phase_nxt = PH_INT;
              end else if (c == CH_POINT) begin
                phase_nxt = PH_FRAC_FIRST;
              end else begin
                phase_nxt = PH_END;
              end
            end
            PH_FRAC_FIRST: begin
              if (is_dig) begin
                frac_first_nxt = dig;
                phase_nxt      = PH_FRAC_REST;
              end else begin
                phase_nxt = PH_END;
              end
            end
            PH_FRAC_REST: begin
              if (is_dig) begin
                if (dig != 4'd0) frac_tail_nxt = 1'b1;
              end else begin
                phase_nxt = PH_END;
              end
            end
            default: begin
              phase_nxt = PH_END;
            end
          endcase
        end
      end else begin
        token_length_nxt = '0;
        phase_nxt        = PH_LEAD;
        int_nz_nxt       = 1'b0;
        frac_first_nxt   = 4'd0;
        frac_tail_nxt    = 1'b0;
        if (token_length_r != '0) begin
          for (int k = 0; k < MASK_BITS; k++) begin
            if ((int'(value_count_r) == k) && above) mask_acc_nxt[k] = 1'b1;
          end
          if (int'(value_count_r) + 1 >= VALUES_PER_GROUP) begin
            emit            = 1'b1;
            value_count_nxt = '0;
          end else begin
            value_count_nxt = value_count_r + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mask_nxt  = out_mask_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_mask_nxt  = mask_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_length_r <= '0;
      phase_r        <= PH_LEAD;
      int_nz_r       <= 1'b0;
      frac_first_r   <= 4'd0;
      frac_tail_r    <= 1'b0;
      value_count_r  <= '0;
      mask_acc_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      token_length_r <= token_length_nxt;
      phase_r        <= phase_nxt;
      int_nz_r       <= int_nz_nxt;
      frac_first_r   <= frac_first_nxt;
      frac_tail_r    <= frac_tail_nxt;
      value_count_r  <= value_count_nxt;
      mask_acc_r     <= emit ? '0 : mask_acc_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r <= out_mask_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - MASK_BITS){1'b0}}, out_mask_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(value_count_r) < VALUES_PER_GROUP)
    else $error("value count out of range");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(token_length_r) <= TOKEN_CAPACITY)
    else $error("token length beyond capacity");

  a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_delim) |=> (token_length_r == '0 && phase_r == PH_LEAD))
    else $error("delimiter did not clear token state");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && value_count_r == '0 && mask_acc_r == '0))
    else $error("completed group not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> !$past(in_xfer))
    else $error("byte taken while result stalled");

endmodule
